// ===== rtl/bmf_pkg.sv =====
package bmf_pkg;

  // Width of the window_count register and its value after reset.
  localparam int COUNT_W     = 5;
  localparam int COUNT_RESET = 5;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT,
    CMD_CLEAR
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/bmf_cell.sv =====
module bmf_cell import bmf_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int IDX_W       = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_cmd_t              cmd,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [IDX_W-1:0]       new_idx,
  input  logic                   prev_gt,
  input  logic [SAMPLE_BITS-1:0] prev_value,
  input  logic [IDX_W-1:0]       prev_idx,
  input  logic                   prev_valid,
  input  logic [SAMPLE_BITS-1:0] next_value,
  input  logic [IDX_W-1:0]       next_idx,
  input  logic                   next_valid,
  output logic [SAMPLE_BITS-1:0] value,
  output logic [IDX_W-1:0]       idx,
  output logic                   valid,
  output logic                   gt
);

  logic [SAMPLE_BITS-1:0] value_next;
  logic [IDX_W-1:0]       idx_next;
  logic                   valid_next;

  // An empty cell counts as holding a value above any sample.
  assign gt = !valid || (value > sample);

  always_comb begin
    value_next = value;
    idx_next   = idx;
    valid_next = valid;
    unique case (cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        // The first cell above the sample takes it; those further up move one place up.
        if (gt) begin
          if (prev_gt) begin
            value_next = prev_value;
            idx_next   = prev_idx;
            valid_next = prev_valid;
          end else begin
            value_next = sample;
            idx_next   = new_idx;
            valid_next = 1'b1;
          end
        end
      end
      CMD_SHIFT: begin
        value_next = next_value;
        idx_next   = next_idx;
        valid_next = next_valid;
      end
      CMD_CLEAR: begin
        valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    idx   <= idx_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== rtl/block_median_filter.sv =====
// Median-of-N filter over a stream of converter samples.
// Samples enter on the s_axis channel, one item per handshake. They are kept
// in a row of cells sorted by value as they arrive, each tagged with its
// place in the window. The sample that completes a window of window_count
// items (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) starts a
// scan: the row shifts towards cell 0 once a cycle, counting entries of the
// window, until the entry at sorted index (limited count)/2 is at the head.
// That value goes to the m_axis output register and the row is emptied.
// A sample that does not complete a window leaves s_axis_tready high for the
// next one. A completing sample holds s_axis_tready low while the scan shifts
// the row; the median is then loaded into the m_axis output register.
// If the receiver stalls, the finished median waits in the output register
// while new samples are still taken; a scan that finds its median before
// the register is free pauses at that point.
// Reset empties the window and sets window_count to 5; cfg_we writes it.
module block_median_filter import bmf_pkg::*; #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [COUNT_W-1:0]                      cfg_wdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata   // median
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

  logic [COUNT_W-1:0]     window_count;
  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       fill_next;
  logic [CNT_W-1:0]       sel;
  logic [CNT_W-1:0]       sel_next;
  logic [CNT_W-1:0]       eff_count;
  logic [CNT_W-1:0]       rank;
  state_t                 state;
  state_t                 state_next;
  cell_cmd_t              cmd;
  logic                   out_valid;
  logic                   out_valid_next;
  logic                   load_out;
  logic [SAMPLE_BITS-1:0] median;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   head_sel;

  logic [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
  logic [IDX_W-1:0]       cell_idx   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  cell_valid;
  logic [MAX_WINDOW-1:0]  cell_gt;

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(median);

  always_comb begin
    if (window_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(window_count) > MAX_WINDOW) begin
      eff_count = CNT_W'(MAX_WINDOW);
    end else begin
      eff_count = CNT_W'(window_count);
    end
  end

  assign rank     = eff_count >> 1;
  assign head_sel = cell_valid[0] && (CNT_W'(cell_idx[0]) < eff_count);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                   p_gt;
    logic [SAMPLE_BITS-1:0] p_value;
    logic [IDX_W-1:0]       p_idx;
    logic                   p_valid;
    logic [SAMPLE_BITS-1:0] n_value;
    logic [IDX_W-1:0]       n_idx;
    logic                   n_valid;

    if (i == 0) begin : g_first
      assign p_gt    = 1'b0;
      assign p_value = '0;
      assign p_idx   = '0;
      assign p_valid = 1'b0;
    end else begin : g_inner
      assign p_gt    = cell_gt[i-1];
      assign p_value = cell_value[i-1];
      assign p_idx   = cell_idx[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign n_value = '0;
      assign n_idx   = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_value = cell_value[i+1];
      assign n_idx   = cell_idx[i+1];
      assign n_valid = cell_valid[i+1];
    end

    bmf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .sample     (sample),
      .new_idx    (fill[IDX_W-1:0]),
      .prev_gt    (p_gt),
      .prev_value (p_value),
      .prev_idx   (p_idx),
      .prev_valid (p_valid),
      .next_value (n_value),
      .next_idx   (n_idx),
      .next_valid (n_valid),
      .value      (cell_value[i]),
      .idx        (cell_idx[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      sel          <= '0;
      out_valid    <= 1'b0;
      window_count <= COUNT_W'(COUNT_RESET);
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        window_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median <= cell_value[0];
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    sel_next       = sel;
    cmd            = CMD_HOLD;
    load_out       = 1'b0;
    out_valid_next = out_valid && !m_axis_tready;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd = CMD_INSERT;
          if ((CNT_W + 1)'(fill) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(eff_count)) begin
            fill_next  = '0;
            sel_next   = '0;
            state_next = ST_SCAN;
          end else begin
            fill_next = fill + CNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (head_sel && (sel == rank)) begin
          // The median is at the head; it waits here until the output register is free.
          if (!out_valid || m_axis_tready) begin
            load_out       = 1'b1;
            out_valid_next = 1'b1;
            cmd            = CMD_CLEAR;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd = CMD_SHIFT;
          if (head_sel) begin
            sel_next = sel + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Occupied cells always form an unbroken run from cell 0.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid + MAX_WINDOW'(1)))
    else $error("occupied cells are not contiguous from the head");

  // While scanning, the head cell always holds an entry.
  a_scan_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> cell_valid[0])
    else $error("scan ran past the end of the window");

  // A freshly loaded median leaves the row empty and the input open.
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ((cell_valid == '0) && (state == ST_IDLE)))
    else $error("row not emptied after the median was taken");

  // The fill count stays below the row length.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) < MAX_WINDOW)
    else $error("fill count out of range");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bmf_pkg::*;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 10;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = MAX_WINDOW + 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;   // sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;        // median

  block_median_filter #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Samples waiting to be offered, and medians the filter still owes us.
  logic [SAMPLE_BITS-1:0] sample_queue[$];
  logic [SAMPLE_BITS-1:0] expected_medians[$];

  // Our own copy of the filter state.
  logic [SAMPLE_BITS-1:0] window_copy[MAX_WINDOW];
  int                     fill_copy = 0;
  logic [COUNT_W-1:0]     count_setting = COUNT_RESET;

  int error_count = 0;
  int accepted_samples = 0;
  int pressure_mark = 32'h7fffffff;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Store the sample and, if it closes the window, work out the median.
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
    int count;
    int slot;
    int i;
    int j;
    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] sorted_buf[MAX_WINDOW];
    count = int'(count_setting);
    if (count == 0) count = 1;
    if (count > MAX_WINDOW) count = MAX_WINDOW;
    slot = fill_copy;
    if (slot >= MAX_WINDOW) slot = MAX_WINDOW - 1;
    window_copy[slot] = s;
    if (slot + 1 >= count) begin
      for (i = 0; i < count; i++) begin
        v = window_copy[i];
        j = i;
        while (j > 0 && sorted_buf[j-1] > v) begin
          sorted_buf[j] = sorted_buf[j-1];
          j--;
        end
        sorted_buf[j] = v;
      end
      expected_medians.push_back(sorted_buf[count/2]);
      fill_copy = 0;
    end else begin
      fill_copy = slot + 1;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_sample(s_axis_tdata[SAMPLE_BITS-1:0]);
        void'(sample_queue.pop_front());
        accepted_samples <= accepted_samples + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= DATA_W'(sample_queue[0]);
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changes its stall pattern whenever a random timer runs out, and
  // once holds off for a long stretch so that the filter backs up.
  int stall_mode = 0;
  int mode_timer = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && accepted_samples >= pressure_mark) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_timer == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_timer <= $urandom_range(20, 80);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Output checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_medians.size() == 0) begin
        report_mismatch($sformatf("unexpected median %0d",
                                  m_axis_tdata[SAMPLE_BITS-1:0]));
      end else begin
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== expected_medians[0])
          report_mismatch($sformatf("median got %0d expected %0d",
                                    m_axis_tdata[SAMPLE_BITS-1:0],
                                    expected_medians[0]));
        void'(expected_medians.pop_front());
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return SAMPLE_BITS'($urandom_range(500, 507));
      default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endcase
  endfunction

  // Waits until every item is taken and every median is back, then lets
  // the filter finish any scan that produced nothing.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || expected_medians.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_setting = value;
  endtask

  task automatic push_random(input int n);
    repeat (n) sample_queue.push_back(random_sample());
  endtask

  int pushed;
  int phase_len;
  int phase_idx;
  int pick;
  logic [COUNT_W-1:0] next_count;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window of five, extremes of the sample range.
    sample_queue.push_back(10'd0);
    sample_queue.push_back(10'd1023);
    sample_queue.push_back(10'd512);
    sample_queue.push_back(10'd1);
    sample_queue.push_back(10'd1022);

    // A count of zero behaves as one: every sample is its own median.
    write_count('0);
    sample_queue.push_back(10'h2aa);
    sample_queue.push_back(10'h155);
    sample_queue.push_back(10'd1023);

    // Counts above the maximum saturate to a full window.
    write_count('1);
    push_random(MAX_WINDOW);

    // Shrink the count part-way through a window; the next sample closes it.
    write_count(COUNT_W'(MAX_WINDOW));
    push_random(3);
    write_count(COUNT_W'(2));
    push_random(1);

    pushed = 25;
    phase_idx = 0;
    while (pushed < 525) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: next_count = '0;
        1: next_count = COUNT_W'($urandom_range(MAX_WINDOW + 1, (1 << COUNT_W) - 1));
        2: next_count = COUNT_W'(MAX_WINDOW);
        3: next_count = COUNT_W'(1);
        default: next_count = COUNT_W'($urandom_range(1, MAX_WINDOW));
      endcase
      if (phase_idx == 3) next_count = COUNT_W'(3);
      write_count(next_count);
      phase_len = $urandom_range(8, 50);
      if (phase_idx == 3) begin
        phase_len = 60;
        pressure_mark = accepted_samples + 2;
      end
      push_random(phase_len);
      pushed += phase_len;
      phase_idx++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_medians.size() != 0)
      report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
